/* sv/ubd_pkg.sv */
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared types and constants for the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubd_pkg;

    localparam int CLOCK_W     = 32;
    localparam int BAUD_W      = 28;
    localparam int INT_W       = 28;
    localparam int FRAC_W      = 7;
    localparam int HALF_SHIFT  = 3;
    localparam int FRAC_BITS   = 7;
    localparam int DIVIDEND_W  = CLOCK_W + HALF_SHIFT;
    localparam int NUM_STAGES  = 5;
    localparam int STAGE_STEPS = DIVIDEND_W / NUM_STAGES;
    localparam int IBRD_HI_W   = 16;

    typedef struct packed {
        logic [BAUD_W-1:0]     rem;
        logic [DIVIDEND_W-1:0] work;
        logic [BAUD_W-1:0]     baud;
        logic                  baud_zero;
    } ubd_div_t;

endpackage

/* sv/uart_baud_divisor_calc_core.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_core
// Computes the integer and fractional UART baud divisors from a reference
// clock and a baud rate. One word per cycle in each direction: eight times
// the clock is divided by the baud rate in a restoring divider of five
// register stages, seven quotient bits each, followed by an output stage that
// rounds the fraction to sixty-fourths (it can reach 64) and flags a zero baud
// rate or an integer divisor outside 1..65535. Every stage holds on a stall and
// fills bubbles, so throughput is set by the output handshake alone.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ubd_pkg::CLOCK_W-1:0] s_clock_hz,
    input  logic [ubd_pkg::BAUD_W-1:0]  s_baud_rate,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ubd_pkg::INT_W-1:0]   m_int_divisor,
    output logic [ubd_pkg::FRAC_W-1:0]  m_frac_divisor,
    output logic                        m_divisor_error
);
    import ubd_pkg::*;

    logic     pipe_valid [NUM_STAGES+1];
    logic     pipe_ready [NUM_STAGES+1];
    ubd_div_t pipe_data  [NUM_STAGES+1];

    assign pipe_valid[0]          = s_valid;
    assign s_ready                = pipe_ready[0];
    assign pipe_data[0].rem       = '0;
    assign pipe_data[0].work      = {s_clock_hz, {HALF_SHIFT{1'b0}}};
    assign pipe_data[0].baud      = s_baud_rate;
    assign pipe_data[0].baud_zero = (s_baud_rate == '0);

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
        ubd_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_data   (pipe_data[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_data  (pipe_data[g+1])
        );
    end

    ubd_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (pipe_valid[NUM_STAGES]),
        .in_ready        (pipe_ready[NUM_STAGES]),
        .in_data         (pipe_data[NUM_STAGES]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_int_divisor   (m_int_divisor),
        .m_frac_divisor  (m_frac_divisor),
        .m_divisor_error (m_divisor_error)
    );

endmodule

/* sv/ubd_div_stage.sv */
// ----------------------------------------------------------------------------
// ubd_div_stage
// One register stage of the restoring divider: a fixed number of quotient
// bits per stage, shifted into the low end of the working word.
// ----------------------------------------------------------------------------
module ubd_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ubd_pkg::ubd_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ubd_pkg::ubd_div_t out_data
);
    import ubd_pkg::*;

    logic     valid_reg;
    ubd_div_t data_reg;
    ubd_div_t data_next;

    always_comb begin
        logic [BAUD_W:0] trial;
        data_next = in_data;
        for (int i = 0; i < STAGE_STEPS; i++) begin
            trial = {data_next.rem, data_next.work[DIVIDEND_W-1]};
            if (trial >= {1'b0, data_next.baud}) begin
                trial         = trial - {1'b0, data_next.baud};
                data_next.work = {data_next.work[DIVIDEND_W-2:0], 1'b1};
            end else begin
                data_next.work = {data_next.work[DIVIDEND_W-2:0], 1'b0};
            end
            data_next.rem = trial[BAUD_W-1:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/ubd_out_stage.sv */
// ----------------------------------------------------------------------------
// ubd_out_stage
// Split the quotient into integer and fractional divisor, round the
// fraction, flag unusable divisors and hold the result word.
// ----------------------------------------------------------------------------
module ubd_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ubd_pkg::ubd_div_t          in_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ubd_pkg::INT_W-1:0]  m_int_divisor,
    output logic [ubd_pkg::FRAC_W-1:0] m_frac_divisor,
    output logic                       m_divisor_error
);
    import ubd_pkg::*;

    logic              valid_reg;
    logic [INT_W-1:0]  int_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              err_reg;
    logic [INT_W-1:0]  int_next;
    logic [FRAC_W-1:0] frac_next;
    logic              err_next;
    logic [INT_W-1:0]  quot_int;
    logic [FRAC_BITS-1:0] quot_frac;

    assign quot_int  = in_data.work[DIVIDEND_W-1:FRAC_BITS];
    assign quot_frac = in_data.work[FRAC_BITS-1:0];

    always_comb begin
        if (in_data.baud_zero) begin
            int_next  = '0;
            frac_next = '0;
            err_next  = 1'b1;
        end else begin
            int_next  = quot_int;
            frac_next = {1'b0, quot_frac[FRAC_BITS-1:1]} + {{(FRAC_W-1){1'b0}}, quot_frac[0]};
            err_next  = (quot_int == '0) || (quot_int[INT_W-1:IBRD_HI_W] != '0);
        end
    end

    assign in_ready        = !valid_reg || m_ready;
    assign m_valid         = valid_reg;
    assign m_int_divisor   = int_reg;
    assign m_frac_divisor  = frac_reg;
    assign m_divisor_error = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            int_reg  <= int_next;
            frac_reg <= frac_next;
            err_reg  <= err_next;
        end
    end

endmodule
